// ----- rtl/voxel_face_visibility_macros.svh -----
// Assertion macros shared by the voxel face visibility checker.
`ifndef VOXEL_FACE_VISIBILITY_MACROS_SVH
`define VOXEL_FACE_VISIBILITY_MACROS_SVH

// Checked on every clock edge outside reset.
`define VFV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every clock edge, reset included.
`define VFV_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/vfv_pkg.sv -----
// Types and constants of the voxel face visibility block.
package vfv_pkg;

   localparam int COORD_W = 5;
   localparam int MASK_W  = 6;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam int FACE_BACK   = 0;
   localparam int FACE_FRONT  = 1;
   localparam int FACE_TOP    = 2;
   localparam int FACE_BOTTOM = 3;
   localparam int FACE_LEFT   = 4;
   localparam int FACE_RIGHT  = 5;

   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
   localparam logic [STEP_W-1:0] STEP_BACK   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_FRONT  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_TOP    = 3'd3;
   localparam logic [STEP_W-1:0] STEP_BOTTOM = 3'd4;
   localparam logic [STEP_W-1:0] STEP_DONE   = 3'd5;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_READ,
      ST_WR_WRITE,
      ST_QUERY
   } state_type;

endpackage

// ----- rtl/voxel_face_visibility.sv -----
// Voxel face visibility: occupancy row memory with a read-modify-write sequencer.
// A query reads five rows through the single read port with busy high, then strobes a registered
// result; a new request is taken only once busy has fallen again.
// A write reads and writes back one row, with busy high in ST_WR_READ and ST_WR_WRITE.
// After reset a clearing sweep writes SIDE*SIDE rows, one per cycle, with busy high.
// Results are strobed for one cycle; the receiver cannot stall.
module voxel_face_visibility #(
   parameter int SIDE = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_kind,
   input  logic [vfv_pkg::COORD_W-1:0]  req_pos_x,
   input  logic [vfv_pkg::COORD_W-1:0]  req_pos_y,
   input  logic [vfv_pkg::COORD_W-1:0]  req_pos_z,
   input  logic                         req_solid,
   output logic                         rsp_valid,
   output logic [vfv_pkg::MASK_W-1:0]   rsp_face_mask,
   output logic                         rsp_visible
);
   import vfv_pkg::*;

   localparam int DEPTH = SIDE * SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = COORD_W + 1;
   localparam int EW    = ($clog2(SIDE + 1) > NW) ? $clog2(SIDE + 1) : NW;

   // Row (y*SIDE + z) holds bit x for voxel (x, y, z).
   logic [SIDE-1:0]   occ_mem_ff [DEPTH];
   logic [SIDE-1:0]   rd_row_ff;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic               solid_ff, solid_in;
   logic               center_ff, center_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic [MASK_W-1:0]  rsp_mask_ff, rsp_mask_in;
   logic               rsp_visible_ff, rsp_visible_in;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [SIDE-1:0]   mem_wdata;
   logic [SIDE-1:0]   bit_sel;
   logic [NW-1:0]     xm, xp, ym, yp, zm, zp;
   logic [AW-1:0]     center_addr;
   logic              in_cube, step_bit;
   logic [STEP_W-1:0] prev_step;
   logic [MASK_W-1:0] final_mask;

   function automatic logic [AW-1:0] row_addr(input logic [NW-1:0] y, input logic [NW-1:0] z);
      return AW'(AW'(y) * AW'(SIDE) + AW'(z));
   endfunction

   function automatic logic row_bit(input logic [SIDE-1:0] row, input logic [NW-1:0] idx);
      logic [SIDE-1:0] sh;
      sh = row >> idx;
      return sh[0];
   endfunction

   function automatic logic at_low(input logic [COORD_W-1:0] c);
      return c == '0;
   endfunction

   function automatic logic at_high(input logic [COORD_W-1:0] c);
      return EW'(c) == EW'(SIDE - 1);
   endfunction

   assign xm = NW'(x_ff) - NW'(1);
   assign xp = NW'(x_ff) + NW'(1);
   assign ym = NW'(y_ff) - NW'(1);
   assign yp = NW'(y_ff) + NW'(1);
   assign zm = NW'(z_ff) - NW'(1);
   assign zp = NW'(z_ff) + NW'(1);

   assign center_addr = row_addr(NW'(y_ff), NW'(z_ff));
   assign in_cube     = (EW'(x_ff) < EW'(SIDE)) && (EW'(y_ff) < EW'(SIDE))
                        && (EW'(z_ff) < EW'(SIDE));
   assign bit_sel     = SIDE'(1) << x_ff;
   assign step_bit    = row_bit(rd_row_ff, NW'(x_ff));
   assign prev_step   = cnt_ff - STEP_W'(1);

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_face_mask = rsp_mask_ff;
   assign rsp_visible   = rsp_visible_ff;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      clr_in         = clr_ff;
      rsp_valid_in   = 1'b0;
      x_in           = x_ff;
      y_in           = y_ff;
      z_in           = z_ff;
      solid_in       = solid_ff;
      center_in      = center_ff;
      mask_in        = mask_ff;
      rsp_mask_in    = rsp_mask_ff;
      rsp_visible_in = rsp_visible_ff;
      mem_we         = 1'b0;
      mem_waddr      = center_addr;
      mem_wdata      = rd_row_ff;
      mem_raddr      = center_addr;
      final_mask     = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               x_in      = req_pos_x;
               y_in      = req_pos_y;
               z_in      = req_pos_z;
               solid_in  = req_solid;
               center_in = 1'b0;
               mask_in   = '0;
               cnt_in    = STEP_CENTER;
               state_in  = (req_kind == KIND_QUERY) ? ST_QUERY : ST_WR_READ;
            end
         end
         ST_WR_READ: begin
            state_in = ST_WR_WRITE;
         end
         ST_WR_WRITE: begin
            // Positions outside the SIDE-wide cube are dropped.
            mem_we    = in_cube;
            mem_wdata = solid_ff ? (rd_row_ff | bit_sel) : (rd_row_ff & ~bit_sel);
            state_in  = ST_IDLE;
         end
         ST_QUERY: begin
            case (cnt_ff)
               STEP_CENTER: mem_raddr = center_addr;
               STEP_BACK:   mem_raddr = row_addr(NW'(y_ff), zm);
               STEP_FRONT:  mem_raddr = row_addr(NW'(y_ff), zp);
               STEP_TOP:    mem_raddr = row_addr(yp, NW'(z_ff));
               STEP_BOTTOM: mem_raddr = row_addr(ym, NW'(z_ff));
               default:     mem_raddr = center_addr;
            endcase
            // The row read in the previous step is in rd_row_ff now.
            case (prev_step)
               STEP_CENTER: begin
                  center_in           = step_bit;
                  mask_in[FACE_LEFT]  = at_low(x_ff) | ~row_bit(rd_row_ff, xm);
                  mask_in[FACE_RIGHT] = at_high(x_ff) | ~row_bit(rd_row_ff, xp);
               end
               STEP_BACK:   mask_in[FACE_BACK]   = at_low(z_ff) | ~step_bit;
               STEP_FRONT:  mask_in[FACE_FRONT]  = at_high(z_ff) | ~step_bit;
               STEP_TOP:    mask_in[FACE_TOP]    = at_high(y_ff) | ~step_bit;
               STEP_BOTTOM: mask_in[FACE_BOTTOM] = at_low(y_ff) | ~step_bit;
               default: ;
            endcase
            if (cnt_ff == STEP_DONE) begin
               final_mask     = (in_cube && center_ff) ? mask_in : '0;
               rsp_mask_in    = final_mask;
               rsp_visible_in = |final_mask;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + STEP_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= STEP_CENTER;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff           <= x_in;
      y_ff           <= y_in;
      z_ff           <= z_in;
      solid_ff       <= solid_in;
      center_ff      <= center_in;
      mask_ff        <= mask_in;
      rsp_mask_ff    <= rsp_mask_in;
      rsp_visible_ff <= rsp_visible_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         occ_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_row_ff <= occ_mem_ff[mem_raddr];
   end

endmodule

// ----- rtl/vfv_checker.sv -----
// Port-level checker for the voxel face visibility block and its bind.
`include "voxel_face_visibility_macros.svh"

module vfv_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_kind,
   input logic [vfv_pkg::COORD_W-1:0]  req_pos_x,
   input logic [vfv_pkg::COORD_W-1:0]  req_pos_y,
   input logic [vfv_pkg::COORD_W-1:0]  req_pos_z,
   input logic                         req_solid,
   input logic                         rsp_valid,
   input logic [vfv_pkg::MASK_W-1:0]   rsp_face_mask,
   input logic                         rsp_visible
);
   import vfv_pkg::*;

   logic query_xfer, write_xfer;

   assign query_xfer = start && !busy && (req_kind == KIND_QUERY);
   assign write_xfer = start && !busy && (req_kind == KIND_WRITE);

   // The clearing sweep keeps the block busy and silent right after reset.
   `VFV_ASSERT_ALWAYS(a_reset_clears, reset |=> busy && !rsp_valid, "no clearing sweep after reset")
   `VFV_ASSERT(a_query_latency, query_xfer |-> ##7 rsp_valid, "query result missing")
   `VFV_ASSERT(a_write_silent, write_xfer |=> !rsp_valid ##1 !rsp_valid, "write gave a result")
   `VFV_ASSERT(a_visible_flag, rsp_valid |-> (rsp_visible == (rsp_face_mask != '0)), "visible flag wrong")

endmodule

bind voxel_face_visibility vfv_checker u_vfv_checker (.*);

// ----- sim/tb_voxel_face_visibility.sv -----
// Testbench for the voxel face visibility block: random and directed voxel traffic.
module tb_voxel_face_visibility;
   timeunit 1ns;
   timeprecision 1ps;

   import vfv_pkg::*;

   localparam int CUBE_SIDE = 32;
   localparam int RANDOM_ITEMS = 900;
   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic                kind;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [COORD_W-1:0]  z;
      logic                solid;
   } voxel_cmd_type;

   typedef struct packed {
      logic [MASK_W-1:0]   face_mask;
      logic                visible;
   } face_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_kind = KIND_WRITE;
   logic [COORD_W-1:0]  req_pos_x = '0;
   logic [COORD_W-1:0]  req_pos_y = '0;
   logic [COORD_W-1:0]  req_pos_z = '0;
   logic                req_solid = 1'b0;
   logic                rsp_valid;
   logic [MASK_W-1:0]   rsp_face_mask;
   logic                rsp_visible;

   voxel_cmd_type    voxel_cmds[$];
   face_result_type  face_results_due[$];
   logic [CUBE_SIDE-1:0] occupancy[0:CUBE_SIDE*CUBE_SIDE-1];
   int            mismatch_count = 0;
   int            gap_left = 0;
   int            transfers_done = 0;
   bit            steady_burst = 1'b0;

   voxel_face_visibility #(.SIDE(CUBE_SIDE)) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .req_solid     (req_solid),
      .rsp_valid     (rsp_valid),
      .rsp_face_mask (rsp_face_mask),
      .rsp_visible   (rsp_visible)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit voxel_is_solid(int x, int y, int z);
      if (x < 0 || y < 0 || z < 0 || x >= CUBE_SIDE || y >= CUBE_SIDE || z >= CUBE_SIDE) begin
         return 1'b0;
      end
      return occupancy[y*CUBE_SIDE + z][x];
   endfunction

   function automatic logic [MASK_W-1:0] exposed_faces(int x, int y, int z);
      logic [MASK_W-1:0] faces;
      faces = '0;
      if (!voxel_is_solid(x, y, z)) begin
         return faces;
      end
      faces[FACE_BACK]   = (z == 0) || !voxel_is_solid(x, y, z-1);
      faces[FACE_FRONT]  = (z == CUBE_SIDE-1) || !voxel_is_solid(x, y, z+1);
      faces[FACE_TOP]    = (y == CUBE_SIDE-1) || !voxel_is_solid(x, y+1, z);
      faces[FACE_BOTTOM] = (y == 0) || !voxel_is_solid(x, y-1, z);
      faces[FACE_LEFT]   = (x == 0) || !voxel_is_solid(x-1, y, z);
      faces[FACE_RIGHT]  = (x == CUBE_SIDE-1) || !voxel_is_solid(x+1, y, z);
      return faces;
   endfunction

   // Update the occupancy copy for a write, or queue the faces a query must return.
   task automatic apply_voxel_cmd(voxel_cmd_type cmd);
      face_result_type due;
      if (cmd.kind == KIND_WRITE) begin
         occupancy[int'(cmd.y)*CUBE_SIDE + int'(cmd.z)][cmd.x] = cmd.solid;
      end else begin
         due.face_mask = exposed_faces(int'(cmd.x), int'(cmd.y), int'(cmd.z));
         due.visible = (due.face_mask != '0);
         face_results_due.push_back(due);
      end
   endtask

   task automatic add_cmd(logic kind, int x, int y, int z, logic solid);
      voxel_cmd_type cmd;
      cmd.kind = kind;
      cmd.x = COORD_W'(x);
      cmd.y = COORD_W'(y);
      cmd.z = COORD_W'(z);
      cmd.solid = solid;
      voxel_cmds.push_back(cmd);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_burst || r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 9);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic int pick_base();
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) begin
         return 0;
      end else if (r == 1) begin
         return CUBE_SIDE - 4;
      end
      return $urandom_range(0, CUBE_SIDE - 4);
   endfunction

   task automatic note_mismatch(string what, int expected, int actual);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch on %s at %0t: expected %0d, got %0d", what, $time, expected, actual);
      end
   endtask

   // Driver: the item on the ports is taken at an edge where start is high and busy low.
   always @(posedge clock) begin
      voxel_cmd_type held;
      voxel_cmd_type next_cmd;
      held = '{req_kind, req_pos_x, req_pos_y, req_pos_z, req_solid};
      if (!reset) begin
         if (start && !busy) begin
            apply_voxel_cmd(held);
            transfers_done++;
            if (transfers_done % 60 == 0) begin
               steady_burst = ($urandom_range(0, 2) == 0);
            end
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (voxel_cmds.size() > 0) begin
               next_cmd = voxel_cmds.pop_front();
               req_kind  <= next_cmd.kind;
               req_pos_x <= next_cmd.x;
               req_pos_y <= next_cmd.y;
               req_pos_z <= next_cmd.z;
               req_solid <= next_cmd.solid;
               start     <= 1'b1;
               gap_left = pick_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result is matched against the oldest query still due.
   always @(posedge clock) begin
      face_result_type due;
      if (!reset && rsp_valid === 1'b1) begin
         if (face_results_due.size() == 0) begin
            note_mismatch("unexpected result, face_mask", -1, int'(rsp_face_mask));
         end else begin
            due = face_results_due.pop_front();
            if (rsp_face_mask !== due.face_mask) begin
               note_mismatch("face_mask", int'(due.face_mask), int'(rsp_face_mask));
            end
            if (rsp_visible !== due.visible) begin
               note_mismatch("visible", int'(due.visible), int'(rsp_visible));
            end
         end
      end
   end

   initial begin
      int base_x;
      int base_y;
      int base_z;
      int x;
      int y;
      int z;
      logic kind;
      logic solid;

      foreach (occupancy[i]) begin
         occupancy[i] = '0;
      end

      // Empty cube, then lone voxels in opposite corners.
      add_cmd(KIND_QUERY, 0, 0, 0, 1'b0);
      add_cmd(KIND_WRITE, 0, 0, 0, 1'b1);
      add_cmd(KIND_QUERY, 0, 0, 0, 1'b1);
      add_cmd(KIND_WRITE, 31, 31, 31, 1'b1);
      add_cmd(KIND_QUERY, 31, 31, 31, 1'b0);
      add_cmd(KIND_WRITE, 1, 0, 0, 1'b1);
      add_cmd(KIND_QUERY, 0, 0, 0, 1'b0);
      // A voxel fully enclosed by its six neighbours shows no face.
      add_cmd(KIND_WRITE, 16, 16, 16, 1'b1);
      add_cmd(KIND_WRITE, 15, 16, 16, 1'b1);
      add_cmd(KIND_WRITE, 17, 16, 16, 1'b1);
      add_cmd(KIND_WRITE, 16, 15, 16, 1'b1);
      add_cmd(KIND_WRITE, 16, 17, 16, 1'b1);
      add_cmd(KIND_WRITE, 16, 16, 15, 1'b1);
      add_cmd(KIND_WRITE, 16, 16, 17, 1'b1);
      add_cmd(KIND_QUERY, 16, 16, 16, 1'b1);
      add_cmd(KIND_QUERY, 17, 16, 16, 1'b0);
      add_cmd(KIND_WRITE, 16, 16, 16, 1'b0);
      add_cmd(KIND_QUERY, 16, 16, 16, 1'b0);
      add_cmd(KIND_QUERY, 15, 16, 16, 1'b0);
      add_cmd(KIND_WRITE, 0, 0, 0, 1'b0);
      add_cmd(KIND_QUERY, 1, 0, 0, 1'b0);
      add_cmd(KIND_QUERY, 21, 10, 21, 1'b1);

      // Random traffic clustered in small blocks so that neighbours are often solid.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 60 == 0) begin
            base_x = pick_base();
            base_y = pick_base();
            base_z = pick_base();
         end
         if ($urandom_range(0, 9) == 0) begin
            x = $urandom_range(0, CUBE_SIDE-1);
            y = $urandom_range(0, CUBE_SIDE-1);
            z = $urandom_range(0, CUBE_SIDE-1);
         end else begin
            x = base_x + $urandom_range(0, 3);
            y = base_y + $urandom_range(0, 3);
            z = base_z + $urandom_range(0, 3);
         end
         kind = ($urandom_range(0, 99) < 45) ? KIND_QUERY : KIND_WRITE;
         solid = (kind == KIND_WRITE) ? ($urandom_range(0, 9) < 7) : 1'($urandom_range(0, 1));
         add_cmd(kind, x, y, z, solid);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      do begin
         @(negedge clock);
      end while (voxel_cmds.size() != 0 || start);
      while (face_results_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && face_results_due.size() == 0) begin
         $display("PASS voxel_face_visibility");
      end else begin
         $display("FAIL voxel_face_visibility");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("FAIL voxel_face_visibility");
      $finish;
   end

endmodule
